// File: hw/rtl/enfe_pkg.sv
// Shared constants, widths and controller/datapath handshake types for the noise-floor estimator.
`default_nettype none

package enfe_pkg;

    // Default ring depths
    localparam int LONG_DEPTH_DEF  = 200;
    localparam int SHORT_DEPTH_DEF = 50;

    // Field widths
    localparam int SAMPLE_W = 18;
    localparam int NP_W     = 17;
    localparam int CLEAN_W  = 20;

    // Fixed-point constants (Q16 unless noted)
    localparam logic [17:0] ONE_Q16   = 18'd65536;     // 1.0
    localparam logic [17:0] AVG_RESET = 18'd3277;      // 0.05
    localparam logic [13:0] W_Q20     = 14'd4194;      // 0.004 in Q20
    localparam logic [14:0] NP_Q16    = 15'd19661;     // 0.3
    localparam logic [16:0] NP_MIN    = 17'd328;       // 0.005
    localparam logic [17:0] K24_Q16   = 18'd157286;    // 2.4
    localparam logic [27:0] OFS_Q32   = 28'd214748365; // 0.05 in Q32
    localparam logic [16:0] G11_Q16   = 17'd72090;     // 1.1

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // take a sample, advance rings, write slots
        logic scan;     // issue one ring read
        logic upd;      // form the average correction product
        logic avg;      // apply the correction
        logic mula;     // noise-power and offset products
        logic sub;      // noise-power rounding and zero-mean difference
        logic mulb;     // gain partial products
        logic fin;      // round and saturate the clean signal
        logic load_out; // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last; // current read is the last one of the scan
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hw/rtl/enfe_if.sv
// Valid/ready channel interfaces for the sample input and the estimate output.
`default_nettype none

interface enfe_in_if;
    logic                               valid;
    logic                               ready;
    logic [enfe_pkg::SAMPLE_W-1:0]      sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface enfe_out_if;
    logic                               valid;
    logic                               ready;
    logic [enfe_pkg::NP_W-1:0]          noise_power;
    logic signed [enfe_pkg::CLEAN_W-1:0] clean_signal;

    modport source (output valid, output noise_power, output clean_signal, input ready);
    modport sink   (input valid, input noise_power, input clean_signal, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/enfe_ctrl.sv
// Controller state machine that sequences one sample through scan and arithmetic steps.
`default_nettype none

module enfe_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire enfe_pkg::t_dp_stat i_stat,
    output enfe_pkg::t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_FLUSH = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_AVG   = 4'd4;
    localparam logic [3:0] S_MULA  = 4'd5;
    localparam logic [3:0] S_SUB   = 4'd6;
    localparam logic [3:0] S_MULB  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_AVG;
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_MULA;
            end
            S_MULA: begin
                o_cmd.mula = 1'b1;
                n_state    = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_MULB;
            end
            S_MULB: begin
                o_cmd.mulb = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/enfe_dp.sv
// Datapath: window rings, minimum scan, floor average and output arithmetic.
`default_nettype none

module enfe_dp #(
    parameter int LONG_DEPTH  = enfe_pkg::LONG_DEPTH_DEF,
    parameter int SHORT_DEPTH = enfe_pkg::SHORT_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire enfe_pkg::t_dp_cmd                  i_cmd,
    output enfe_pkg::t_dp_stat                      o_stat,
    input  wire logic [enfe_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [enfe_pkg::NP_W-1:0]               o_noise_power,
    output logic signed [enfe_pkg::CLEAN_W-1:0]     o_clean_signal
);

    localparam int LAW  = $clog2(LONG_DEPTH);
    localparam int SAW  = $clog2(SHORT_DEPTH);
    localparam int LFW  = $clog2(LONG_DEPTH + 1);
    localparam int SFW  = $clog2(SHORT_DEPTH + 1);
    localparam int MAXD = (LONG_DEPTH > SHORT_DEPTH) ? LONG_DEPTH : SHORT_DEPTH;
    localparam int IW   = $clog2(MAXD);
    localparam int MFW  = $clog2(MAXD + 1);

    localparam logic signed [13:0] W_S   = $signed(enfe_pkg::W_Q20);
    localparam logic signed [17:0] G11_S = $signed({1'b0, enfe_pkg::G11_Q16});
    localparam logic signed [19:0] CLEAN_MAX = 20'sd524287;
    localparam logic signed [19:0] CLEAN_MIN = -20'sd524288;

    // Window memories
    logic [17:0] r_lmem [LONG_DEPTH];
    logic [17:0] r_smem [SHORT_DEPTH];
    logic [17:0] r_lrd;
    logic [17:0] r_srd;

    // Ring control
    logic [LAW-1:0] r_lslot, n_lslot;
    logic [SAW-1:0] r_sslot, n_sslot;
    logic [LFW-1:0] r_lfill, n_lfill;
    logic [SFW-1:0] r_sfill, n_sfill;
    logic           n_wr;
    logic           r_lw0, r_lw1, r_sw0, r_sw1;

    // Scan control
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_scan_last;
    logic [MFW-1:0] n_scan_len;
    logic           n_lrd_en, n_srd_en;
    logic           r_lcmp_en, r_scmp_en;
    logic           r_lforce, r_sforce;
    logic [17:0]    l_val, s_val;

    // Arithmetic registers
    logic [17:0]        r_x;
    logic [17:0]        r_lmin, r_smin;
    logic [17:0]        r_avg;
    logic [17:0]        m_min;
    logic signed [18:0] n_diff;
    logic signed [32:0] r_upd;
    logic signed [32:0] n_upd_rnd;
    logic signed [19:0] n_avg_sum;
    logic [32:0]        r_np_prod;
    logic [35:0]        r_p1;
    logic [17:0]        n_np_rnd;
    logic [16:0]        r_np;
    logic signed [37:0] r_t;
    logic signed [39:0] r_ph;
    logic [32:0]        r_pl;
    logic signed [56:0] n_sum;
    logic signed [24:0] n_v;
    logic signed [19:0] r_clean;

    // Output register
    logic               r_out_vld;
    logic [16:0]        r_out_np;
    logic signed [19:0] r_out_clean;

    // Ring position and fill advance for the accepted sample
    always_comb begin
        n_lslot = (r_lslot == LAW'(LONG_DEPTH - 1)) ? '0 : r_lslot + 1'b1;
        n_sslot = (r_sslot == SAW'(SHORT_DEPTH - 1)) ? '0 : r_sslot + 1'b1;
        n_lfill = (r_lfill == LFW'(LONG_DEPTH)) ? r_lfill : r_lfill + 1'b1;
        n_sfill = (r_sfill == SFW'(SHORT_DEPTH)) ? r_sfill : r_sfill + 1'b1;
        n_wr    = (n_sfill > SFW'(2));
        n_scan_len = (MFW'(n_lfill) > MFW'(n_sfill)) ? MFW'(n_lfill) : MFW'(n_sfill);
    end

    // Read enables and substitution of slots 0 and 1 until first written
    always_comb begin
        n_lrd_en = i_cmd.scan && (MFW'(r_idx) < MFW'(r_lfill));
        n_srd_en = i_cmd.scan && (MFW'(r_idx) < MFW'(r_sfill));
        l_val    = r_lforce ? enfe_pkg::ONE_Q16 : r_lrd;
        s_val    = r_sforce ? enfe_pkg::ONE_Q16 : r_srd;
    end

    // Status: last scan read and room in the output register
    assign o_stat = {(r_idx == r_scan_last), (!r_out_vld || i_out_ready)};

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && n_wr) begin
            r_lmem[n_lslot] <= i_sample;
            r_smem[n_sslot] <= i_sample;
        end
        if (n_lrd_en) begin
            r_lrd <= r_lmem[r_idx[LAW-1:0]];
        end
        if (n_srd_en) begin
            r_srd <= r_smem[r_idx[SAW-1:0]];
        end
    end

    // Ring state, minima and average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lslot   <= '0;
            r_sslot   <= '0;
            r_lfill   <= LFW'(1);
            r_sfill   <= SFW'(1);
            r_lw0     <= 1'b0;
            r_lw1     <= 1'b0;
            r_sw0     <= 1'b0;
            r_sw1     <= 1'b0;
            r_idx     <= '0;
            r_lcmp_en <= 1'b0;
            r_scmp_en <= 1'b0;
            r_lmin    <= enfe_pkg::ONE_Q16;
            r_smin    <= enfe_pkg::ONE_Q16;
            r_avg     <= enfe_pkg::AVG_RESET;
        end else begin
            r_lcmp_en <= n_lrd_en;
            r_scmp_en <= n_srd_en;
            if (i_cmd.accept) begin
                r_lslot <= n_lslot;
                r_sslot <= n_sslot;
                r_lfill <= n_lfill;
                r_sfill <= n_sfill;
                r_idx   <= '0;
                if (n_wr) begin
                    r_lmin <= i_sample;
                    r_smin <= i_sample;
                    if (n_lslot == LAW'(0)) r_lw0 <= 1'b1;
                    if (n_lslot == LAW'(1)) r_lw1 <= 1'b1;
                    if (n_sslot == SAW'(0)) r_sw0 <= 1'b1;
                    if (n_sslot == SAW'(1)) r_sw1 <= 1'b1;
                end
            end else begin
                if (i_cmd.scan) begin
                    r_idx <= r_idx + 1'b1;
                end
                // Running minimum, one slot per cycle behind the read
                if (r_lcmp_en && (l_val <= r_lmin)) begin
                    r_lmin <= l_val;
                end
                if (r_scmp_en && (s_val <= r_smin)) begin
                    r_smin <= s_val;
                end
            end
            if (i_cmd.avg) begin
                if (n_avg_sum < 20'sd0) begin
                    r_avg <= '0;
                end else if (n_avg_sum > 20'sd262143) begin
                    r_avg <= '1;
                end else begin
                    r_avg <= n_avg_sum[17:0];
                end
            end
        end
    end

    // Scan bookkeeping without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x         <= i_sample;
            r_scan_last <= IW'(n_scan_len - 1'b1);
        end
        r_lforce <= ((r_idx == IW'(0)) && !r_lw0) || ((r_idx == IW'(1)) && !r_lw1);
        r_sforce <= ((r_idx == IW'(0)) && !r_sw0) || ((r_idx == IW'(1)) && !r_sw1);
    end

    // Average correction and output arithmetic
    always_comb begin
        m_min     = (r_smin < r_lmin) ? r_smin : r_lmin;
        n_diff    = $signed({1'b0, m_min}) - $signed({1'b0, r_avg});
        n_upd_rnd = (r_upd + 33'sd524288) >>> 20;
        n_avg_sum = $signed({2'b00, r_avg}) + n_upd_rnd[19:0];
        n_np_rnd  = 18'((r_np_prod + 33'd32768) >> 16);
        n_sum     = (57'(r_ph) <<< 16) + $signed({24'd0, r_pl}) + 57'sd2147483648;
        n_v       = n_sum[56:32];
    end

    // Arithmetic pipeline registers, one step per command
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_upd <= n_diff * W_S;
        end
        if (i_cmd.mula) begin
            r_np_prod <= r_avg * enfe_pkg::NP_Q16;
            r_p1      <= r_avg * enfe_pkg::K24_Q16;
        end
        if (i_cmd.sub) begin
            if (n_np_rnd < 18'(enfe_pkg::NP_MIN)) begin
                r_np <= enfe_pkg::NP_MIN;
            end else if (n_np_rnd > 18'd131071) begin
                r_np <= '1;
            end else begin
                r_np <= n_np_rnd[16:0];
            end
            r_t <= $signed({4'd0, r_x, 16'd0}) - $signed({2'b00, r_p1})
                 - $signed({10'd0, enfe_pkg::OFS_Q32});
        end
        if (i_cmd.mulb) begin
            r_ph <= $signed(r_t[37:16]) * G11_S;
            r_pl <= r_t[15:0] * enfe_pkg::G11_Q16;
        end
        if (i_cmd.fin) begin
            if (n_v > 25'(CLEAN_MAX)) begin
                r_clean <= CLEAN_MAX;
            end else if (n_v < 25'(CLEAN_MIN)) begin
                r_clean <= CLEAN_MIN;
            end else begin
                r_clean <= n_v[19:0];
            end
        end
    end

    // Output register: holds a finished transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_np    <= r_np;
            r_out_clean <= r_clean;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_noise_power  = r_out_np;
    assign o_clean_signal = r_out_clean;

endmodule

`default_nettype wire

// File: hw/rtl/envelope_noise_floor_estimator.sv
// Top level of the envelope noise-floor estimator: controller plus datapath.
//
//   Channel  Dir  Payload                          Handshake
//   i_in     in   sample[17:0] (Q2.16 unsigned)    valid/ready
//   o_out    out  noise_power[16:0], clean_signal  valid/ready
//                 [19:0] (Q16 signed, saturated)
//
// Ready returns once an accepted transaction has passed the scan of N ring slots, where
// N = max(long fill, short fill), and then the FLUSH, UPD, AVG, MULA, SUB, MULB, FIN and
// OUT states; no new sample is taken before then. With the default depths N reaches 200.
// The scan reads one slot per cycle through the single read port of each ring memory.
// Reset is synchronous, active low; no clearing pass is needed after reset.
// A finished result waits in the output register while the next sample is processed;
// the block stalls only if a second result is ready before the first is taken.
`default_nettype none

module envelope_noise_floor_estimator #(
    parameter int LONG_DEPTH  = enfe_pkg::LONG_DEPTH_DEF,
    parameter int SHORT_DEPTH = enfe_pkg::SHORT_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    enfe_in_if.sink     i_in,
    enfe_out_if.source  o_out
);

    enfe_pkg::t_dp_cmd  cmd;
    enfe_pkg::t_dp_stat stat;
    logic               in_ready;

    // Sequencing
    enfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Storage and arithmetic
    enfe_dp #(
        .LONG_DEPTH  (LONG_DEPTH),
        .SHORT_DEPTH (SHORT_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_sample       (i_in.sample),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_noise_power  (o_out.noise_power),
        .o_clean_signal (o_out.clean_signal)
    );

endmodule

`default_nettype wire
